FILE: src/sma_pkg.sv
// ----------------------------------------------------------------------------
// sma_pkg
// shared constants, opcode and status codes, and the decoded instruction
// type of the stack machine alu
// ----------------------------------------------------------------------------
package sma_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 256;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // field widths
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 4;
  localparam int DEPTH_W  = 9;
  localparam int STATUS_W = 2;

  // decoded instruction queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // opcodes as they arrive on the mode field
  typedef enum logic [MODE_W-1:0] {
    MODE_RET   = 4'd0,
    MODE_PUSH  = 4'd1,
    MODE_PUSH0 = 4'd2,
    MODE_PUSH1 = 4'd3,
    MODE_PUSH2 = 4'd4,
    MODE_LDA   = 4'd5,
    MODE_DEC   = 4'd6,
    MODE_INC   = 4'd7,
    MODE_ADD   = 4'd8,
    MODE_SUB   = 4'd9,
    MODE_MUL   = 4'd10,
    MODE_DIV   = 4'd11,
    MODE_NOP   = 4'd12
  } mode_e;

  // sticky status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_e;

  // operation classes after decode
  typedef enum logic [2:0] {
    OP_RET,
    OP_PUSH,
    OP_INC,
    OP_DEC,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  // decoded instruction: operation and the value a push places on top
  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] value;
  } instr_t;

endpackage

FILE: src/sma_ram.sv
// ----------------------------------------------------------------------------
// sma_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module sma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/sma_front.sv
// ----------------------------------------------------------------------------
// sma_front
// accepts bytecode transactions, decodes the opcode into an operation class
// and the value to push, and drops no-operation codes before the queue
// ----------------------------------------------------------------------------
module sma_front (
  input  logic                       push_i,
  output logic                       full_o,
  input  logic [sma_pkg::MODE_W-1:0] mode_i,
  input  logic [sma_pkg::DATA_W-1:0] immediate_i,
  input  logic                       queue_full_i,
  output logic                       wr_valid_o,
  output sma_pkg::instr_t            wr_instr_o
);
  import sma_pkg::*;

  logic keep;

  // opcode decode
  always_comb begin
    keep             = 1'b1;
    wr_instr_o.op    = OP_PUSH;
    wr_instr_o.value = immediate_i;
    case (mode_i)
      MODE_RET:  wr_instr_o.op = OP_RET;
      MODE_PUSH,
      MODE_LDA:  wr_instr_o.value = immediate_i;
      MODE_PUSH0: wr_instr_o.value = DATA_W'(0);
      MODE_PUSH1: wr_instr_o.value = DATA_W'(1);
      MODE_PUSH2: wr_instr_o.value = DATA_W'(2);
      MODE_DEC:  wr_instr_o.op = OP_DEC;
      MODE_INC:  wr_instr_o.op = OP_INC;
      MODE_ADD:  wr_instr_o.op = OP_ADD;
      MODE_SUB:  wr_instr_o.op = OP_SUB;
      MODE_MUL:  wr_instr_o.op = OP_MUL;
      MODE_DIV:  wr_instr_o.op = OP_DIV;
      default:   keep = 1'b0;  // nop and unused codes
    endcase
  end

  // handshake toward the queue
  assign full_o     = queue_full_i;
  assign wr_valid_o = push_i && !queue_full_i && keep;

endmodule

FILE: src/sma_queue.sv
// ----------------------------------------------------------------------------
// sma_queue
// short fifo of decoded instructions between the front and the back
// ----------------------------------------------------------------------------
module sma_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  input  sma_pkg::instr_t wr_instr_i,
  output logic            full_o,
  output logic            empty_o,
  output sma_pkg::instr_t rd_instr_o,
  input  logic            rd_pop_i
);
  import sma_pkg::*;

  instr_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr_q, wptr_d;
  logic [QPTR_W-1:0]  rptr_q, rptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_wr;
  logic               do_rd;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign rd_instr_o = slot_q[rptr_q];
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage slots
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wptr_q] <= wr_instr_i;
    end
  end

endmodule

FILE: src/sma_back.sv
// ----------------------------------------------------------------------------
// sma_back
// execution unit: top of stack in a register, the rest of the stack in a
// ram, a one bit per cycle divider, sticky status and the result register
// ----------------------------------------------------------------------------
module sma_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         instr_valid_i,
  input  sma_pkg::instr_t              instr_i,
  output logic                         instr_pop_o,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [sma_pkg::DATA_W-1:0]   top_value_o,
  output logic [sma_pkg::DEPTH_W-1:0]  depth_o,
  output logic [sma_pkg::STATUS_W-1:0] status_o
);
  import sma_pkg::*;

  localparam int ITER_W = $clog2(DATA_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_OPER,
    S_DIV,
    S_SIGN
  } state_e;

  state_e              state_q, state_d;
  logic [DATA_W-1:0]   tos_q, tos_d;
  logic [CNT_W-1:0]    count_q, count_d;
  status_e             sticky_q, sticky_d;
  op_e                 op_q, op_d;
  logic [DATA_W-1:0]   rem_q, rem_d;
  logic [DATA_W-1:0]   quo_q, quo_d;
  logic [DATA_W-1:0]   dsr_q, dsr_d;
  logic                neg_q, neg_d;
  logic [ITER_W-1:0]   iter_q, iter_d;
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   out_top_q, out_top_d;
  logic [DEPTH_W-1:0]  out_depth_q, out_depth_d;
  status_e             out_status_q, out_status_d;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;
  logic [DATA_W:0]     rem_shift;
  logic [DATA_W:0]     rem_diff;

  // keep only the first error since the last return
  function automatic status_e flag_error(status_e cur, status_e code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  // entries below the top of stack
  sma_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(tos_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // divider step: shift in the next dividend bit and trial subtract
  assign rem_shift = {rem_q, quo_q[DATA_W-1]};
  assign rem_diff  = rem_shift - {1'b0, dsr_q};

  // sequencer
  always_comb begin
    state_d      = state_q;
    tos_d        = tos_q;
    count_d      = count_q;
    sticky_d     = sticky_q;
    op_d         = op_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    dsr_d        = dsr_q;
    neg_d        = neg_q;
    iter_d       = iter_q;
    out_valid_d  = out_valid_q;
    out_top_d    = out_top_q;
    out_depth_d  = out_depth_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = ADDR_W'(count_q - 1'b1);
    ram_re       = 1'b0;
    ram_raddr    = ADDR_W'(count_q - CNT_W'(2));
    instr_pop_o  = 1'b0;

    // result taken by the consumer
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (instr_valid_i) begin
          case (instr_i.op)
            OP_PUSH: begin
              instr_pop_o = 1'b1;
              if (count_q == CNT_W'(STACK_DEPTH)) begin
                sticky_d = flag_error(sticky_q, ST_OVERFLOW);
              end else begin
                // old top spills into the ram
                ram_we  = (count_q != '0);
                tos_d   = instr_i.value;
                count_d = count_q + 1'b1;
              end
            end
            OP_INC, OP_DEC: begin
              instr_pop_o = 1'b1;
              if (count_q == '0) begin
                sticky_d = flag_error(sticky_q, ST_UNDERFLOW);
              end else if (instr_i.op == OP_INC) begin
                tos_d = tos_q + 1'b1;
              end else begin
                tos_d = tos_q - 1'b1;
              end
            end
            OP_RET: begin
              // wait for a free result register
              if (!out_valid_q || pop_i) begin
                instr_pop_o  = 1'b1;
                out_valid_d  = 1'b1;
                out_top_d    = (count_q != '0) ? tos_q : '0;
                out_depth_d  = DEPTH_W'(count_q);
                out_status_d = sticky_q;
                sticky_d     = ST_OK;
              end
            end
            default: begin
              // binary operations fetch the second operand
              instr_pop_o = 1'b1;
              if (count_q < CNT_W'(2)) begin
                sticky_d = flag_error(sticky_q, ST_UNDERFLOW);
              end else begin
                ram_re  = 1'b1;
                op_d    = instr_i.op;
                state_d = S_OPER;
              end
            end
          endcase
        end
      end
      S_OPER: begin
        state_d = S_IDLE;
        case (op_q)
          OP_ADD: begin
            tos_d   = ram_rdata + tos_q;
            count_d = count_q - 1'b1;
          end
          OP_SUB: begin
            tos_d   = ram_rdata - tos_q;
            count_d = count_q - 1'b1;
          end
          OP_MUL: begin
            tos_d   = ram_rdata * tos_q;
            count_d = count_q - 1'b1;
          end
          OP_DIV: begin
            if (tos_q == '0) begin
              sticky_d = flag_error(sticky_q, ST_DIVZERO);
            end else begin
              // divide magnitudes, fix the sign at the end
              neg_d   = ram_rdata[DATA_W-1] ^ tos_q[DATA_W-1];
              quo_d   = ram_rdata[DATA_W-1] ? -ram_rdata : ram_rdata;
              dsr_d   = tos_q[DATA_W-1] ? -tos_q : tos_q;
              rem_d   = '0;
              iter_d  = '0;
              state_d = S_DIV;
            end
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (!rem_diff[DATA_W]) begin
          rem_d = rem_diff[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b1};
        end else begin
          rem_d = rem_shift[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b0};
        end
        iter_d = iter_q + 1'b1;
        if (iter_q == ITER_W'(DATA_W - 1)) begin
          state_d = S_SIGN;
        end
      end
      S_SIGN: begin
        tos_d   = neg_q ? -quo_q : quo_q;
        count_d = count_q - 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      tos_q        <= '0;
      count_q      <= '0;
      sticky_q     <= ST_OK;
      op_q         <= OP_ADD;
      rem_q        <= '0;
      quo_q        <= '0;
      dsr_q        <= '0;
      neg_q        <= 1'b0;
      iter_q       <= '0;
      out_valid_q  <= 1'b0;
      out_top_q    <= '0;
      out_depth_q  <= '0;
      out_status_q <= ST_OK;
    end else begin
      state_q      <= state_d;
      tos_q        <= tos_d;
      count_q      <= count_d;
      sticky_q     <= sticky_d;
      op_q         <= op_d;
      rem_q        <= rem_d;
      quo_q        <= quo_d;
      dsr_q        <= dsr_d;
      neg_q        <= neg_d;
      iter_q       <= iter_d;
      out_valid_q  <= out_valid_d;
      out_top_q    <= out_top_d;
      out_depth_q  <= out_depth_d;
      out_status_q <= out_status_d;
    end
  end

  assign empty_o     = !out_valid_q;
  assign top_value_o = out_top_q;
  assign depth_o     = out_depth_q;
  assign status_o    = out_status_q;

endmodule

FILE: src/stack_machine_alu_top.sv
// ----------------------------------------------------------------------------
// stack_machine_alu_top
// bytecode interpreter on a 32-bit signed operand stack
// ----------------------------------------------------------------------------
// Each push transaction carries one instruction. The front decodes it and
// drops no-operation codes at once; everything else waits in a four-entry
// queue for the execution unit, which keeps the top of stack in a register
// and the entries below it in a single-port-read stack ram. In the execution
// unit push, push0/1/2, lda, inc, dec and ret complete in the idle state; add, sub
// and mul first read the second operand from the ram, and div goes through
// ram read, setup, 32 steps of a one bit per cycle divider and sign fix. A
// binary op on fewer than two entries skips the ram read, and a div by zero
// stops after it. Errors leave the stack unchanged and keep the first error
// code until the next ret. A ret places top value, depth and status in a
// one-entry result register; a ret behind an untaken result waits. The stack
// ram is not cleared at reset, no clearing pass is needed, and only written
// entries are ever read.
// ----------------------------------------------------------------------------
module stack_machine_alu_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [sma_pkg::MODE_W-1:0]   mode_i,
  input  logic [sma_pkg::DATA_W-1:0]   immediate_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [sma_pkg::DATA_W-1:0]   top_value_o,
  output logic [sma_pkg::DEPTH_W-1:0]  depth_o,
  output logic [sma_pkg::STATUS_W-1:0] status_o
);
  import sma_pkg::*;

  logic   q_wr_valid;
  instr_t q_wr_instr;
  logic   q_full;
  logic   q_empty;
  instr_t q_rd_instr;
  logic   q_pop;

  // accept and decode
  sma_front u_front (
    .push_i      (push),
    .full_o      (full),
    .mode_i      (mode_i),
    .immediate_i (immediate_i),
    .queue_full_i(q_full),
    .wr_valid_o  (q_wr_valid),
    .wr_instr_o  (q_wr_instr)
  );

  // decoded instruction queue
  sma_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(q_wr_valid),
    .wr_instr_i(q_wr_instr),
    .full_o    (q_full),
    .empty_o   (q_empty),
    .rd_instr_o(q_rd_instr),
    .rd_pop_i  (q_pop)
  );

  // execution
  sma_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .instr_valid_i(!q_empty),
    .instr_i      (q_rd_instr),
    .instr_pop_o  (q_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .top_value_o  (top_value_o),
    .depth_o      (depth_o),
    .status_o     (status_o)
  );

endmodule

FILE: src/sma_checker.sv
// ----------------------------------------------------------------------------
// sma_checker
// port-level checks of the stack machine alu, bound to the top level
// ----------------------------------------------------------------------------
module sma_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         push,
  input logic                         full,
  input logic [sma_pkg::MODE_W-1:0]   mode_i,
  input logic [sma_pkg::DATA_W-1:0]   immediate_i,
  input logic                         empty,
  input logic                         pop,
  input logic [sma_pkg::DATA_W-1:0]   top_value_o,
  input logic [sma_pkg::DEPTH_W-1:0]  depth_o,
  input logic [sma_pkg::STATUS_W-1:0] status_o
);
  import sma_pkg::*;

  localparam int PEND_W = $clog2(QUEUE_DEPTH + 3);

  logic [PEND_W-1:0] pending_q, pending_d;
  logic              ret_in;
  logic              res_out;

  // returns accepted but not yet taken
  assign ret_in  = push && !full && (mode_i == MODE_RET);
  assign res_out = pop && !empty;

  always_comb begin
    pending_d = pending_q;
    if (ret_in && !res_out) begin
      pending_d = pending_q + 1'b1;
    end else if (res_out && !ret_in) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // a result only ever follows an accepted return
  a_result_needs_ret: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> pending_q != '0)
    else $error("result shown without a pending return");

  // reported depth never exceeds the stack size
  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> 32'(depth_o) <= STACK_DEPTH)
    else $error("reported depth beyond stack size");

  // an empty stack reports a zero top value
  a_empty_top_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (STACK_DEPTH < 512) && !empty && depth_o == '0 |-> top_value_o == '0)
    else $error("nonzero top value on empty stack");

  // a waiting result holds until taken
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(top_value_o) && $stable(depth_o)
      && $stable(status_o))
    else $error("waiting result changed");

endmodule

bind stack_machine_alu_top sma_checker u_sma_checker (.*);

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// testbench for the stack machine alu: bytecode stream in, ret reports out
// ----------------------------------------------------------------------------
// A short directed table opens the run: empty-stack errors, wrap at the
// extremes, most negative over minus one, divide by zero and unused opcodes.
// Random expressions follow, along with noise and one fill of the whole
// stack to overflow. A stack predictor in the bench works out every ret
// report, and a result checker compares each popped transaction with the
// oldest expected report. Sender and receiver idle at random in phases, and
// one long receiver hold-off backs the block up until it stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
  import sma_pkg::*;

  // unused opcodes, executed as no-operation
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd13;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int END_WAIT       = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_REPORTS    = 10;

  // one ret report
  typedef struct packed {
    logic [DATA_W-1:0]   top;
    logic [DEPTH_W-1:0]  depth;
    logic [STATUS_W-1:0] status;
  } report_t;

  // directed row: instruction plus a report typed in where it is obvious
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] imm;
    logic              fixed;
    report_t           want;
  } dir_row_t;

  localparam report_t NO_REPORT = '0;

  localparam dir_row_t DIR_TABLE [25] = '{
    '{MODE_RET,       32'd0,         1'b1, '{32'd0, 9'd0, ST_OK}},
    '{MODE_ADD,       32'd0,         1'b0, NO_REPORT},
    '{MODE_DEC,       32'd0,         1'b0, NO_REPORT},
    '{MODE_RET,       32'd0,         1'b1, '{32'd0, 9'd0, ST_UNDERFLOW}},
    '{MODE_PUSH,      32'h7FFF_FFFF, 1'b0, NO_REPORT},
    '{MODE_INC,       32'd0,         1'b0, NO_REPORT},
    '{MODE_RET,       32'd0,         1'b1, '{32'h8000_0000, 9'd1, ST_OK}},
    '{MODE_DEC,       32'd0,         1'b0, NO_REPORT},
    '{MODE_LDA,       32'h8000_0000, 1'b0, NO_REPORT},
    '{MODE_PUSH,      32'hFFFF_FFFF, 1'b0, NO_REPORT},
    '{MODE_DIV,       32'd0,         1'b0, NO_REPORT},
    '{MODE_PUSH0,     32'hFFFF_FFFF, 1'b0, NO_REPORT},
    '{MODE_DIV,       32'd0,         1'b0, NO_REPORT},
    '{MODE_RET,       32'd0,         1'b1, '{32'd0, 9'd3, ST_DIVZERO}},
    '{MODE_SUB,       32'd0,         1'b0, NO_REPORT},
    '{MODE_SUB,       32'd0,         1'b0, NO_REPORT},
    '{MODE_PUSH1,     32'd0,         1'b0, NO_REPORT},
    '{MODE_INC,       32'd0,         1'b0, NO_REPORT},
    '{MODE_PUSH2,     32'd0,         1'b0, NO_REPORT},
    '{MODE_MUL,       32'd0,         1'b0, NO_REPORT},
    '{MODE_ADD,       32'd0,         1'b0, NO_REPORT},
    '{MODE_NOP,       32'hFFFF_FFFF, 1'b0, NO_REPORT},
    '{MODE_UNUSED_LO, 32'd7,         1'b0, NO_REPORT},
    '{MODE_UNUSED_HI, 32'd0,         1'b0, NO_REPORT},
    '{MODE_RET,       32'd0,         1'b0, NO_REPORT}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                push        = 1'b0;
  logic                full;
  logic [MODE_W-1:0]   mode_i      = '0;
  logic [DATA_W-1:0]   immediate_i = '0;
  logic                empty;
  logic                pop         = 1'b0;
  logic [DATA_W-1:0]   top_value_o;
  logic [DEPTH_W-1:0]  depth_o;
  logic [STATUS_W-1:0] status_o;

  // predicted stack state
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  int                stack_cnt = 0;
  status_e           sticky_st = ST_OK;

  report_t report_q [$];

  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_req   = 0;
  int items_sent = 0;
  int reports_ok = 0;
  int mismatches = 0;
  int max_depth  = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int idle_cycles = 0;

  stack_machine_alu_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .mode_i      (mode_i),
    .immediate_i (immediate_i),
    .empty       (empty),
    .pop         (pop),
    .top_value_o (top_value_o),
    .depth_o     (depth_o),
    .status_o    (status_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // keep only the first error since the last ret
  function automatic void raise_status(input status_e code);
    if (sticky_st == ST_OK) sticky_st = code;
  endfunction

  function automatic void stack_push(input logic [DATA_W-1:0] value);
    if (stack_cnt >= STACK_DEPTH) begin
      raise_status(ST_OVERFLOW);
    end else begin
      stack_mem[stack_cnt] = value;
      stack_cnt++;
    end
  endfunction

  // signed division truncating toward zero, done on magnitudes
  function automatic logic [DATA_W-1:0] div_trunc(input logic [DATA_W-1:0] num,
                                                  input logic [DATA_W-1:0] den);
    logic [DATA_W-1:0] mag_n, mag_d, quo;
    mag_n = num[DATA_W-1] ? (32'd0 - num) : num;
    mag_d = den[DATA_W-1] ? (32'd0 - den) : den;
    quo   = mag_n / mag_d;
    return (num[DATA_W-1] ^ den[DATA_W-1]) ? (32'd0 - quo) : quo;
  endfunction

  // stack predictor: execute one instruction, return 1 when it reports
  function automatic bit stack_exec(input logic [MODE_W-1:0] m,
                                    input logic [DATA_W-1:0] imm,
                                    output report_t rep);
    logic [DATA_W-1:0] lhs, rhs;
    bit                emit;
    emit = 1'b0;
    rep  = '0;
    case (m)
      MODE_RET: begin
        rep.top    = (stack_cnt > 0) ? stack_mem[stack_cnt-1] : '0;
        rep.depth  = stack_cnt[DEPTH_W-1:0];
        rep.status = sticky_st;
        sticky_st  = ST_OK;
        emit       = 1'b1;
      end
      MODE_PUSH, MODE_LDA: stack_push(imm);
      MODE_PUSH0:          stack_push(32'd0);
      MODE_PUSH1:          stack_push(32'd1);
      MODE_PUSH2:          stack_push(32'd2);
      MODE_DEC, MODE_INC: begin
        if (stack_cnt == 0) raise_status(ST_UNDERFLOW);
        else if (m == MODE_DEC) stack_mem[stack_cnt-1] = stack_mem[stack_cnt-1] - 32'd1;
        else stack_mem[stack_cnt-1] = stack_mem[stack_cnt-1] + 32'd1;
      end
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
        if (stack_cnt < 2) begin
          raise_status(ST_UNDERFLOW);
        end else begin
          lhs = stack_mem[stack_cnt-2];
          rhs = stack_mem[stack_cnt-1];
          if (m == MODE_DIV && rhs == '0) begin
            raise_status(ST_DIVZERO);
          end else begin
            case (m)
              MODE_ADD: stack_mem[stack_cnt-2] = lhs + rhs;
              MODE_SUB: stack_mem[stack_cnt-2] = lhs - rhs;
              MODE_MUL: stack_mem[stack_cnt-2] = lhs * rhs;
              default:  stack_mem[stack_cnt-2] = div_trunc(lhs, rhs);
            endcase
            stack_cnt--;
          end
        end
      end
      default: ;
    endcase
    return emit;
  endfunction

  // operand values: wide random, small signed, extremes, sign-extended halves
  function automatic logic [DATA_W-1:0] rand_value();
    logic [DATA_W-1:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0, 1:    return r;
      2, 3:    return $urandom_range(0, 16) - 8;
      4: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'hFFFF_FFFF;
          default: return 32'd0;
        endcase
      end
      default: return {{16{r[15]}}, r[15:0]};
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] rand_push_mode();
    case ($urandom_range(0, 5))
      0, 1:    return MODE_PUSH;
      2:       return MODE_LDA;
      3:       return MODE_PUSH0;
      4:       return MODE_PUSH1;
      default: return MODE_PUSH2;
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] rand_alu_mode(input bit with_div);
    case ($urandom_range(0, with_div ? 3 : 2))
      0:       return MODE_ADD;
      1:       return MODE_SUB;
      2:       return MODE_MUL;
      default: return MODE_DIV;
    endcase
  endfunction

  // offer one instruction, wait for the transaction, then predict it
  task automatic send_item(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] imm,
                           input logic fixed, input report_t want);
    report_t pred;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push        <= 1'b1;
    mode_i      <= m;
    immediate_i <= imm;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
    if (stack_exec(m, imm, pred)) report_q.push_back(fixed ? want : pred);
    @(negedge clk_i);
  endtask

  // sender pause until every expected report has come, then optional tail
  task automatic settle(input int tail);
    push <= 1'b0;
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // random expressions with some noise mixed in
  task automatic run_random(input int count);
    int                start, n_push, n_ops;
    logic [MODE_W-1:0] m;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(99) < 80) begin
        n_push = $urandom_range(1, 4);
        repeat (n_push) send_item(rand_push_mode(), rand_value(), 1'b0, NO_REPORT);
        n_ops = $urandom_range(n_push / 2, n_push + 2);
        repeat (n_ops) begin
          case ($urandom_range(0, 9))
            6, 7:    m = $urandom_range(0, 1) ? MODE_INC : MODE_DEC;
            8:       m = MODE_NOP;
            9:       m = MODE_RET;
            default: m = rand_alu_mode(1'b1);
          endcase
          send_item(m, $urandom, 1'b0, NO_REPORT);
        end
        // keep the stack shallow outside the fill sequence
        while (stack_cnt > 24) send_item(rand_alu_mode(1'b0), $urandom, 1'b0, NO_REPORT);
        if ($urandom_range(99) < 60) send_item(MODE_RET, $urandom, 1'b0, NO_REPORT);
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(MODE_W'($urandom_range(0, 15)), $urandom, 1'b0, NO_REPORT);
      end
    end
  endtask

  // fill the whole stack, push past the top, then fold it back down
  task automatic run_fill();
    send_item(MODE_RET, $urandom, 1'b0, NO_REPORT);
    while (stack_cnt < STACK_DEPTH) send_item(rand_push_mode(), rand_value(), 1'b0, NO_REPORT);
    repeat (2) send_item(rand_push_mode(), rand_value(), 1'b0, NO_REPORT);
    send_item(MODE_RET, $urandom, 1'b0, NO_REPORT);
    while (stack_cnt > 1)
      send_item(rand_alu_mode($urandom_range(0, 9) == 0), $urandom, 1'b0, NO_REPORT);
    send_item(MODE_RET, $urandom, 1'b0, NO_REPORT);
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // compare each popped transaction with the oldest expected report
  always @(posedge clk_i) begin : check_reports
    report_t exp_r;
    if (rst_ni && pop && !empty) begin
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected report: top=%h depth=%0d status=%0d",
                   top_value_o, depth_o, status_o);
      end else begin
        exp_r = report_q.pop_front();
        if (exp_r.top !== top_value_o || exp_r.depth !== depth_o ||
            exp_r.status !== status_o) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("report mismatch: expected top=%h depth=%0d status=%0d,",
                     exp_r.top, exp_r.depth, exp_r.status,
                     " got top=%h depth=%0d status=%0d",
                     top_value_o, depth_o, status_o);
        end
        reports_ok++;
        status_seen[status_o]++;
        if (depth_o > max_depth) max_depth = depth_o;
      end
    end
  end

  // watchdog: cycles without any transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d reports outstanding",
                 idle_cycles, report_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // stimulus phases
  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (DIR_TABLE[i])
      send_item(DIR_TABLE[i].mode, DIR_TABLE[i].imm, DIR_TABLE[i].fixed, DIR_TABLE[i].want);
    settle(0);

    // no idling
    run_random(400);
    settle(0);

    // sender idle, full stack sequence included
    idle_pct = 58;
    run_fill();
    run_random(120);
    settle(0);

    // receiver stalls, long hold-off while ret transactions keep coming
    idle_pct  = 0;
    stall_pct = 58;
    hold_req  = HOLD_CYCLES;
    repeat (20) begin
      send_item(rand_push_mode(), rand_value(), 1'b0, NO_REPORT);
      send_item(MODE_RET, $urandom, 1'b0, NO_REPORT);
    end
    run_random(360);
    settle(0);

    // both sides idle
    idle_pct  = 34;
    stall_pct = 34;
    run_random(420);

    idle_pct  = 0;
    stall_pct = 0;
    settle(END_WAIT);

    $display("ran %0d instructions, checked %0d ret reports, deepest reported stack %0d",
             items_sent, reports_ok, max_depth);
    $display("statuses at ret: ok %0d, overflow %0d, underflow %0d, divide by zero %0d",
             status_seen[ST_OK], status_seen[ST_OVERFLOW], status_seen[ST_UNDERFLOW],
             status_seen[ST_DIVZERO]);
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
